// ----- hw/rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, reset values and register codes of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SAMPLE_W           = 24;
  localparam int DELAY_W            = 17;
  localparam int GAIN_W             = 16;
  localparam int PDATA_W            = 32;
  localparam int PADDR_W            = 4;
  localparam int DEFAULT_RING_DEPTH = 131072;
  localparam int OUTQ_DEPTH         = 4;

  localparam logic [DELAY_W-1:0] RST_DELAY = DELAY_W'(24000);
  localparam logic [GAIN_W-1:0]  RST_GAIN  = GAIN_W'(32768);
  localparam logic               RST_DUAL  = 1'b1;
  localparam logic [GAIN_W-1:0]  GAIN_CAP  = GAIN_W'(62259);

  typedef enum logic [1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_DUAL  = 2'd2
  } reg_idx_t;

endpackage

// ----- hw/rtl/sfd_in_if.sv -----
// ----------------------------------------------------------------------------
// sfd_in_if
// Input channel: one stereo sample pair and a block end marker per transaction.
// ----------------------------------------------------------------------------
interface sfd_in_if import sfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       block_end;

  modport source (output valid, output left_sample, output right_sample,
                  output block_end, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input block_end, output ready);
endinterface

// ----- hw/rtl/sfd_out_if.sv -----
// ----------------------------------------------------------------------------
// sfd_out_if
// Result channel: one delayed stereo pair and the block end marker.
// ----------------------------------------------------------------------------
interface sfd_out_if import sfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       block_end_out;

  modport source (output valid, output left_out, output right_out,
                  output block_end_out, input ready);
  modport sink   (input valid, input left_out, input right_out,
                  input block_end_out, output ready);
endinterface

// ----- hw/rtl/sfd_ram.sv -----
// ----------------------------------------------------------------------------
// sfd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/stereo_feedback_delay_core.sv -----
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// Stereo feedback comb delay line with an APB register port.
// ----------------------------------------------------------------------------
// The block takes a new input transaction once the previous one has left the
// v1 stage and while the four-entry output queue has room, and passes each
// through the v1, v2 and v3 stages into that queue. The pace is set by the
// single 24 x 17 bit multiplier, which serves the left line in one cycle and
// the right line in the next; each line lives in its own RAM with one read and
// one write port. After reset a clearing pass zeroes all RING_DEPTH entries
// (131072 by default) of both lines, with no input accepted meanwhile. A delay
// write starts a reduction of the delay modulo RING_DEPTH, during which no
// input is accepted either. Register writes are taken at any time.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core import sfd_pkg::*; #(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  sfd_in_if.sink             in_ch,
  sfd_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = 2;
  localparam int QA_W  = $clog2(OUTQ_DEPTH);
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int SCL_W  = PROD_W - GAIN_W;
  localparam int SUM_W  = SAMPLE_W + 2;
  localparam int RED_W  = 2 * DELAY_W + 1;

  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] DIST_RST = PTR_W'(int'(RST_DELAY) % RING_DEPTH);
  localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(2);
  localparam logic [DELAY_W:0]   RECIP   = (DELAY_W+1)'((1 << DELAY_W) / RING_DEPTH);
  localparam logic [DELAY_W-1:0] DEPTH_D = DELAY_W'(RING_DEPTH);
  localparam logic [QA_W:0]    Q_FULL   = (QA_W+1)'(OUTQ_DEPTH);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (GAIN_W - 1));
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       block_end;
  } out_item_t;

  // configuration
  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [GAIN_W-1:0]  gain_cap_r;
  logic               dual_r;
  logic [PTR_W-1:0]   dist_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // delay reduction: reciprocal estimate, back-multiply, one correction
  logic               red_busy_r;
  logic [CNT_W-1:0]   red_cnt_r;
  logic [DELAY_W-1:0] red_d_r;
  logic [DELAY_W-1:0] red_q_r;
  logic [DELAY_W-1:0] red_rem_r;
  logic [RED_W-1:0]   red_prod;
  logic [DELAY_W-1:0] red_qd;
  logic [PTR_W-1:0]   red_step;

  // clearing and pointers
  logic               clr_r;
  logic [PTR_W-1:0]   clr_addr_r;
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   wp_nxt;
  logic [PTR_W:0]     rd_diff;
  logic [PTR_W:0]     rd_wrap;
  logic [PTR_W-1:0]   rd_comb;

  // pipeline
  logic in_acc;
  logic v1_r, v2_r, v3_r;
  logic signed [SAMPLE_W-1:0] s1_lft_r, s1_rgt_r, s2_lft_r, s2_rgt_r, s3_rgt_r;
  logic                       s1_be_r, s2_be_r, s3_be_r;
  logic [PTR_W-1:0]           s1_wp_r, s2_wp_r, s3_wp_r, s1_rd_r, s2_rd_r;
  logic signed [SAMPLE_W-1:0] s2_dl_r, s3_dl_r, s3_dr_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] dl_src, dr_src, mul_a;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [SCL_W-1:0]    scaled;
  logic signed [SAMPLE_W-1:0] add_in;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat_val;

  // last write of each line, for read-after-write forwarding
  logic                       lwl_vld_r, lwr_vld_r;
  logic [PTR_W-1:0]           lwl_addr_r, lwr_addr_r;
  logic signed [SAMPLE_W-1:0] lwl_data_r, lwr_data_r;

  // RAM ports
  logic                l_wr_en, r_wr_en;
  logic [PTR_W-1:0]    l_wr_addr, r_wr_addr;
  logic [SAMPLE_W-1:0] l_wr_data, r_wr_data, l_rd_data, r_rd_data;

  // output queue
  out_item_t          q_mem_r [OUTQ_DEPTH];
  out_item_t          q_head;
  logic [QA_W:0]      qwr_r, qrd_r;
  logic [QA_W:0]      cred_r, cred_nxt;
  logic               q_pop;
  logic               q_full;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DELAY: prdata = PDATA_W'(delay_r);
      REG_GAIN:  prdata = PDATA_W'(gain_r);
      REG_DUAL:  prdata = PDATA_W'(dual_r);
      default:   prdata = '0;
    endcase
  end

  assign red_prod = RED_W'(red_d_r) * RED_W'(RECIP);
  assign red_qd   = red_q_r * DEPTH_D;
  assign red_step = (int'(red_rem_r) >= RING_DEPTH) ? PTR_W'(red_rem_r - DEPTH_D)
                                                    : PTR_W'(red_rem_r);

  // pointers
  assign rd_diff = {1'b0, wp_r} - {1'b0, dist_r};
  assign rd_wrap = rd_diff + DEPTH_X;
  assign rd_comb = rd_diff[PTR_W] ? rd_wrap[PTR_W-1:0] : rd_diff[PTR_W-1:0];
  assign wp_nxt  = (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);

  // handshake
  assign in_ch.ready = !clr_r && !red_busy_r && !v1_r && (cred_r != Q_FULL);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_full      = (qwr_r - qrd_r) == Q_FULL;
  assign q_head      = q_mem_r[qrd_r[QA_W-1:0]];
  assign out_ch.valid         = (qwr_r != qrd_r);
  assign out_ch.left_out      = q_head.left;
  assign out_ch.right_out     = q_head.right;
  assign out_ch.block_end_out = q_head.block_end;
  assign q_pop    = out_ch.valid && out_ch.ready;
  assign cred_nxt = cred_r + (QA_W+1)'(in_acc) - (QA_W+1)'(q_pop);

  // datapath
  assign dl_src = (lwl_vld_r && (lwl_addr_r == s1_rd_r)) ? lwl_data_r
                                                         : $signed(l_rd_data);
  assign dr_src = (lwr_vld_r && (lwr_addr_r == s2_rd_r)) ? lwr_data_r
                                                         : $signed(r_rd_data);
  assign mul_a    = v1_r ? dl_src : dr_src;
  assign prod_nxt = PROD_W'(mul_a * $signed({1'b0, gain_cap_r}));
  assign rnd      = prod_r + RND_HALF;
  assign scaled   = rnd[PROD_W-1:GAIN_W];
  assign add_in   = v2_r ? s2_lft_r : s3_rgt_r;
  assign sum      = {{2{add_in[SAMPLE_W-1]}}, add_in}
                  + {{(SUM_W-SCL_W){scaled[SCL_W-1]}}, scaled};

  always_comb begin
    if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
      sat_val = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  // memories
  assign l_wr_en   = clr_r || v2_r;
  assign l_wr_addr = clr_r ? clr_addr_r : s2_wp_r;
  assign l_wr_data = clr_r ? '0 : sat_val;
  assign r_wr_en   = clr_r || (v3_r && dual_r);
  assign r_wr_addr = clr_r ? clr_addr_r : s3_wp_r;
  assign r_wr_data = clr_r ? '0 : sat_val;

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_left_ram (
    .clk     (clk),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_comb),
    .rd_data (l_rd_data)
  );

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_right_ram (
    .clk     (clk),
    .wr_en   (r_wr_en),
    .wr_addr (r_wr_addr),
    .wr_data (r_wr_data),
    .rd_en   (v1_r),
    .rd_addr (s1_rd_r),
    .rd_data (r_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= RST_DELAY;
      gain_r     <= RST_GAIN;
      gain_cap_r <= RST_GAIN;
      dual_r     <= RST_DUAL;
      dist_r     <= DIST_RST;
      red_busy_r <= 1'b0;
      red_cnt_r  <= '0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      wp_r       <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      lwl_vld_r  <= 1'b0;
      lwr_vld_r  <= 1'b0;
      qwr_r      <= '0;
      qrd_r      <= '0;
      cred_r     <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_DELAY: begin
            delay_r    <= pwdata[DELAY_W-1:0];
            red_busy_r <= 1'b1;
            red_cnt_r  <= RED_LAST;
          end
          REG_GAIN: begin
            gain_r     <= pwdata[GAIN_W-1:0];
            gain_cap_r <= (pwdata[GAIN_W-1:0] > GAIN_CAP) ? GAIN_CAP
                                                          : pwdata[GAIN_W-1:0];
          end
          REG_DUAL:  dual_r <= pwdata[0];
          default:   ;
        endcase
      end
      if (red_busy_r && !(cfg_wr && cfg_idx == REG_DELAY)) begin
        red_cnt_r <= red_cnt_r - CNT_W'(1);
        if (red_cnt_r == '0) begin
          red_busy_r <= 1'b0;
          dist_r     <= red_step;
        end
      end

      if (clr_r) begin
        clr_addr_r <= clr_addr_r + PTR_W'(1);
        if (clr_addr_r == LAST_PTR) begin
          clr_r <= 1'b0;
        end
      end

      if (in_acc) begin
        wp_r <= wp_nxt;
      end
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;

      if (v2_r) begin
        lwl_vld_r <= 1'b1;
      end
      if (v3_r && dual_r) begin
        lwr_vld_r <= 1'b1;
      end

      if (v3_r) begin
        qwr_r <= qwr_r + (QA_W+1)'(1);
      end
      if (q_pop) begin
        qrd_r <= qrd_r + (QA_W+1)'(1);
      end
      cred_r <= cred_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cfg_wr && cfg_idx == REG_DELAY) begin
      red_d_r <= pwdata[DELAY_W-1:0];
    end
    if (red_busy_r) begin
      red_q_r   <= red_prod[2*DELAY_W-1:DELAY_W];
      red_rem_r <= red_d_r - red_qd;
    end

    if (in_acc) begin
      s1_lft_r <= in_ch.left_sample;
      s1_rgt_r <= in_ch.right_sample;
      s1_be_r  <= in_ch.block_end;
      s1_wp_r  <= wp_r;
      s1_rd_r  <= rd_comb;
    end
    if (v1_r) begin
      s2_lft_r <= s1_lft_r;
      s2_rgt_r <= s1_rgt_r;
      s2_be_r  <= s1_be_r;
      s2_wp_r  <= s1_wp_r;
      s2_rd_r  <= s1_rd_r;
      s2_dl_r  <= dl_src;
    end
    if (v2_r) begin
      s3_rgt_r   <= s2_rgt_r;
      s3_be_r    <= s2_be_r;
      s3_wp_r    <= s2_wp_r;
      s3_dl_r    <= s2_dl_r;
      s3_dr_r    <= dr_src;
      lwl_addr_r <= s2_wp_r;
      lwl_data_r <= sat_val;
    end
    if (v1_r || v2_r) begin
      prod_r <= prod_nxt;
    end
    if (v3_r && dual_r) begin
      lwr_addr_r <= s3_wp_r;
      lwr_data_r <= sat_val;
    end
    if (v3_r) begin
      q_mem_r[qwr_r[QA_W-1:0]] <= '{left:      s3_dl_r,
                                    right:     dual_r ? s3_dr_r : s3_dl_r,
                                    block_end: s3_be_r};
    end
  end

  a_mul_share: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && v2_r))
    else $error("multiplier claimed by two transactions");

  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> !q_full)
    else $error("output queue overflow");

  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(v1_r || v2_r || v3_r))
    else $error("transaction in flight during clearing pass");

  a_left_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 (v2_r && l_wr_en))
    else $error("left write-back not two cycles after acceptance");

endmodule

// ----- sim/tb_stereo_feedback_delay_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_core
// Self-checking bench for the stereo feedback comb delay line.
// ----------------------------------------------------------------------------
// Stereo sample pairs are queued by the sequence below and handed to the core
// by a falling-edge driver. A rising-edge monitor runs a local model of both
// delay lines on every accepted input transaction and compares each returned
// transaction against the oldest prediction. Registers are set over APB only
// while the core is drained. Settings cover zero and full-scale delay, gain
// above the cap, both line modes, and idle gaps on either side of the core.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_core import sfd_pkg::*; ();

  localparam int RING         = DEFAULT_RING_DEPTH;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;
  } sample_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       block_end_out;
  } delayed_pair_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  stereo_feedback_delay_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [SAMPLE_W-1:0] left_line  [RING];
  logic signed [SAMPLE_W-1:0] right_line [RING];
  int                         wr_ptr = 0;
  logic [DELAY_W-1:0]         cfg_delay = RST_DELAY;
  logic [GAIN_W-1:0]          cfg_gain  = RST_GAIN;
  logic                       cfg_dual  = RST_DUAL;

  sample_pair_t  sample_queue[$];
  delayed_pair_t expected_pairs[$];
  logic          in_fired;
  int            gap_pct = 0;
  int            stall_pct = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] feedback_sum(
    logic signed [SAMPLE_W-1:0] sample_in,
    logic signed [SAMPLE_W-1:0] delayed,
    logic [GAIN_W-1:0]          gain
  );
    longint prod;
    longint acc;
    prod = longint'(delayed) * longint'({1'b0, gain});
    acc  = longint'(sample_in) + ((prod + 64'sd32768) >>> 16);
    if (acc > longint'(SAMPLE_MAX)) acc = longint'(SAMPLE_MAX);
    if (acc < longint'(SAMPLE_MIN)) acc = longint'(SAMPLE_MIN);
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic delayed_pair_t run_delay_lines(sample_pair_t s);
    int                rd;
    logic [GAIN_W-1:0] g;
    delayed_pair_t     r;
    rd = (wr_ptr + RING - (int'(cfg_delay) % RING)) % RING;
    g  = (cfg_gain > GAIN_CAP) ? GAIN_CAP : cfg_gain;
    r.left_out = left_line[rd];
    left_line[wr_ptr] = feedback_sum(s.left_sample, r.left_out, g);
    if (cfg_dual) begin
      r.right_out = right_line[rd];
      right_line[wr_ptr] = feedback_sum(s.right_sample, r.right_out, g);
    end else begin
      r.right_out = r.left_out;
    end
    r.block_end_out = s.block_end;
    wr_ptr = (wr_ptr + 1) % RING;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($urandom_range(511)) - SAMPLE_W'(256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // driver: launch a new transaction once the previous one is taken
  always @(negedge clk) begin
    sample_pair_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (!in_ch.valid || in_fired) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          nxt = sample_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.left_sample  <= nxt.left_sample;
          in_ch.right_sample <= nxt.right_sample;
          in_ch.block_end    <= nxt.block_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin
    delayed_pair_t want;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_pairs.push_back(run_delay_lines(
          '{in_ch.left_sample, in_ch.right_sample, in_ch.block_end}));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result transaction: left_out %0d right_out %0d",
                 out_ch.left_out, out_ch.right_out);
          error_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_ch.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_ch.left_out);
            error_count++;
          end
          if (out_ch.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_ch.right_out);
            error_count++;
          end
          if (out_ch.block_end_out !== want.block_end_out) begin
            $error("block_end_out: expected %0b, got %0b",
                   want.block_end_out, out_ch.block_end_out);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_stereo_feedback_delay_core: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DELAY: cfg_delay = data[DELAY_W-1:0];
      REG_GAIN:  cfg_gain  = data[GAIN_W-1:0];
      REG_DUAL:  cfg_dual  = data[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [DELAY_W-1:0] delay, input logic [GAIN_W-1:0] gain,
                           input logic dual, input idle_mode_t mode);
    write_reg(REG_DELAY, PDATA_W'(delay));
    write_reg(REG_GAIN, PDATA_W'(gain));
    write_reg(REG_DUAL, PDATA_W'(dual));
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 57; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 57; end
      default:       begin gap_pct = 37; stall_pct = 37; end
    endcase
  endtask

  task automatic queue_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r, input logic b);
    sample_queue.push_back('{l, r, b});
  endtask

  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_ch.valid || expected_pairs.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [DELAY_W-1:0] delay,
                                  input logic [GAIN_W-1:0] gain, input logic dual,
                                  input idle_mode_t mode, input int count);
    configure(delay, gain, dual, mode);
    @(posedge clk);
    repeat (count) queue_pair(pick_sample(), pick_sample(), ($urandom_range(7) == 0));
    wait_drained();
  endtask

  initial begin
    foreach (left_line[i]) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.block_end    = 1'b0;
    out_ch.ready       = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short delay, gain above the cap, saturation at both rails
    configure(DELAY_W'(1), 16'hFFFF, 1'b1, IDLE_NONE);
    @(posedge clk);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    queue_pair('0, '0, 1'b1);
    queue_pair(-24'sd1, 24'sd1, 1'b0);
    queue_pair(24'sd1, -24'sd1, 1'b0);
    queue_pair(-24'sd1, -24'sd1, 1'b0);
    queue_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    queue_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    queue_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    queue_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    queue_pair(24'h555555, 24'hAAAAAA, 1'b0);
    queue_pair(24'hAAAAAA, 24'h555555, 1'b1);
    wait_drained();

    // zero delay, single line, write to an unmapped register
    write_reg(REG_SPARE, PDATA_W'($urandom));
    configure('0, GAIN_CAP, 1'b0, IDLE_NONE);
    @(posedge clk);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    queue_pair(24'sd123, -24'sd77, 1'b0);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    queue_pair(-24'sd1, '0, 1'b1);
    queue_pair('0, SAMPLE_MAX, 1'b0);
    wait_drained();

    run_random_phase(DELAY_W'(3), GAIN_W'(62260), 1'b1, IDLE_NONE, 185);
    run_random_phase(DELAY_W'(2), '0, 1'b1, IDLE_SENDER, 185);
    run_random_phase(DELAY_W'(17), GAIN_W'(45000), 1'b0, IDLE_RECEIVER, 185);
    run_random_phase({DELAY_W{1'b1}}, 16'hFFFF, 1'b1, IDLE_BOTH, 40);
    run_random_phase(DELAY_W'($urandom_range(1, 40)), GAIN_W'($urandom),
                     1'($urandom), IDLE_NONE, 185);
    run_random_phase(DELAY_W'(1), GAIN_CAP, 1'b0, IDLE_SENDER, 185);
    run_random_phase(DELAY_W'($urandom_range(1, 300)), GAIN_W'($urandom),
                     1'b1, IDLE_RECEIVER, 185);
    run_random_phase(DELAY_W'(5), GAIN_W'(1), 1'b1, IDLE_BOTH, 185);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_stereo_feedback_delay_core: PASS");
    end else begin
      $display("tb_stereo_feedback_delay_core: FAIL");
    end
    $finish;
  end

endmodule
